// File: rtl/nca_pkg.sv
// Shared types and constants for the neighbour cache.
`default_nettype none
package nca_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = 13;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1800;

  typedef enum logic [2:0] {
    OP_EXISTS = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_CREATE = 3'd2,
    OP_UPDATE = 3'd3,
    OP_EXPIRE = 3'd4,
    OP_IGNORE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t          op;
    logic [63:0]  kh;
    logic [63:0]  kl;
    logic [47:0]  mac;
    logic [31:0]  now;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              found;
    logic [47:0]       mac;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/nca_front.sv
// Front end: accepts requests, classifies the kind and queues them.
`default_nettype none
module nca_front import nca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [63:0] key_high,
  input  wire logic [63:0] key_low,
  input  wire logic [47:0] mac_in,
  input  wire logic [31:0] now,
  output logic             q_valid,
  output req_t             q_req,
  input  wire logic        q_pop
);

  req_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  op_t        op;

  always_comb begin
    unique case (kind)
      3'd0:    op = OP_EXISTS;
      3'd1:    op = OP_LOOKUP;
      3'd2:    op = OP_CREATE;
      3'd3:    op = OP_UPDATE;
      3'd4:    op = OP_EXPIRE;
      default: op = OP_IGNORE;
    endcase
  end

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != 2'd0);
  assign q_req     = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{op: op, kh: key_high, kl: key_low, mac: mac_in, now: now};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop && q_valid) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> req_stall)
    else $error("queue full without stall");

endmodule
`default_nettype wire

// File: rtl/nca_engine.sv
// Back end: table storage, full-table scan (skipped for reserved kinds) and commit of each request.
`default_nettype none
module nca_engine import nca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] timeout,
  input  wire logic        q_valid,
  input  req_t             q_req,
  output logic             q_pop,
  output logic             res_valid,
  output res_t             res,
  input  wire logic        res_take
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_COMMIT, S_DONE} state_t;

  state_t           state;
  req_t             cur;
  logic [IDX_W-1:0] addr;
  logic             issued_all;

  logic             mem_valid [TABLE_ENTRIES];
  logic [63:0]      mem_kh    [TABLE_ENTRIES];
  logic [63:0]      mem_kl    [TABLE_ENTRIES];
  logic [47:0]      mem_mac   [TABLE_ENTRIES];
  logic [31:0]      mem_use   [TABLE_ENTRIES];

  logic             rd_valid;
  logic [63:0]      rd_kh;
  logic [63:0]      rd_kl;
  logic [47:0]      rd_mac;
  logic [31:0]      rd_use;
  logic             d_vld;
  logic             d_last;
  logic [IDX_W-1:0] d_idx;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [47:0]      hit_mac;
  logic             free_seen;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] count;

  logic             v_we;
  logic [IDX_W-1:0] v_addr;
  logic             v_data;
  logic             key_we, mac_we, use_we;
  logic [IDX_W-1:0] w_addr;
  logic             match, expired;
  logic [31:0]      age;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign res_valid = (state == S_DONE);

  assign age     = cur.now - rd_use;
  assign match   = rd_valid && (rd_kh == cur.kh) && (rd_kl == cur.kl);
  assign expired = rd_valid && (age >= timeout);

  // Write port control
  always_comb begin
    v_we   = 1'b0;
    v_addr = d_idx;
    v_data = 1'b0;
    key_we = 1'b0;
    mac_we = 1'b0;
    use_we = 1'b0;
    w_addr = hit_idx;
    unique case (state)
      S_CLEAR: begin
        v_we   = 1'b1;
        v_addr = addr;
      end
      S_SCAN: begin
        v_we = d_vld && (cur.op == OP_EXPIRE) && expired;
      end
      S_COMMIT: begin
        unique case (cur.op)
          OP_LOOKUP: use_we = hit;
          OP_CREATE: begin
            w_addr = free_idx;
            v_addr = free_idx;
            v_data = 1'b1;
            v_we   = !hit && free_seen;
            key_we = v_we;
            mac_we = v_we;
            use_we = v_we;
          end
          OP_UPDATE: begin
            mac_we = hit && (hit_mac != cur.mac);
            use_we = mac_we;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) mem_valid[v_addr] <= v_data;
    if (key_we) begin
      mem_kh[w_addr] <= cur.kh;
      mem_kl[w_addr] <= cur.kl;
    end
    if (mac_we) mem_mac[w_addr] <= cur.mac;
    if (use_we) mem_use[w_addr] <= cur.now;
    rd_valid <= mem_valid[addr];
    rd_kh    <= mem_kh[addr];
    rd_kl    <= mem_kl[addr];
    rd_mac   <= mem_mac[addr];
    rd_use   <= mem_use[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      issued_all <= 1'b0;
      d_vld      <= 1'b0;
    end else begin
      d_vld  <= (state == S_SCAN) && !issued_all;
      d_idx  <= addr;
      d_last <= (addr == IDX_W'(TABLE_ENTRIES - 1));
      unique case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == IDX_W'(TABLE_ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_req;
            addr       <= '0;
            issued_all <= 1'b0;
            hit        <= 1'b0;
            free_seen  <= 1'b0;
            count      <= '0;
            state      <= (q_req.op == OP_IGNORE) ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issued_all) begin
            addr <= addr + 1'b1;
            if (addr == IDX_W'(TABLE_ENTRIES - 1)) issued_all <= 1'b1;
          end
          if (d_vld) begin
            if (match) begin
              hit     <= 1'b1;
              hit_idx <= d_idx;
              hit_mac <= rd_mac;
            end
            if (!rd_valid && !free_seen) begin
              free_seen <= 1'b1;
              free_idx  <= d_idx;
            end
            if ((cur.op == OP_EXPIRE) && expired && (count != '1)) count <= count + 1'b1;
            if (d_last) state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          res.status <= ST_OK;
          res.found  <= 1'b0;
          res.mac    <= '0;
          res.count  <= '0;
          unique case (cur.op)
            OP_EXISTS: begin
              res.found  <= hit;
              res.status <= hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_LOOKUP: begin
              res.found  <= hit;
              res.mac    <= hit ? hit_mac : 48'd0;
              res.status <= hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_CREATE: res.status <= hit ? ST_PRESENT : (free_seen ? ST_OK : ST_FULL);
            OP_UPDATE: res.status <= hit ? ST_OK : ST_NOT_FOUND;
            OP_EXPIRE: res.count  <= count;
            default: ;
          endcase
          state <= S_DONE;
        end
        S_DONE: if (res_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !q_pop)
    else $error("request taken during clearing pass");
  a_data_in_scan: assert property (@(posedge clk) disable iff (rst)
    d_vld |-> (state == S_SCAN))
    else $error("scan data outside scan");
  a_take_done: assert property (@(posedge clk) disable iff (rst)
    res_take |-> (state == S_DONE))
    else $error("result taken while none pending");

endmodule
`default_nettype wire

// File: rtl/neighbour_cache_with_aging_core.sv
// Top level of the neighbour cache: APB register, front queue, engine, output register.
`default_nettype none
// Neighbour cache: 4096-entry exact-match table from a 128-bit key to a
// 48-bit MAC with a per-entry last-use tick. Every table request (exists,
// lookup, create, update, expire) walks the whole table through one read
// port, one entry per cycle; a reserved kind skips the walk and goes
// straight to the commit state. After reset a clearing pass resets the
// valid bits; requests are held off (req_stall once the two-deep queue
// fills) until it ends. Register 0 at byte address 0 is timeout_ticks
// (reset 1800); write it only while the block is idle.
module neighbour_cache_with_aging_core import nca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [63:0] key_high,
  input  wire logic [63:0] key_low,
  input  wire logic [47:0] mac_in,
  input  wire logic [31:0] now,
  // result channel
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       status,
  output logic             found,
  output logic [47:0]      mac_out,
  output logic [12:0]      expired_count
);

  logic [31:0] timeout_ticks;
  logic        q_valid, q_pop;
  req_t        q_req;
  logic        eng_valid, eng_take;
  res_t        eng_res;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? timeout_ticks : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
      timeout_ticks <= pwdata;
    end
  end

  nca_front u_front (
    .clk, .rst, .req_valid, .req_stall, .kind, .key_high, .key_low, .mac_in, .now,
    .q_valid, .q_req, .q_pop
  );

  nca_engine u_engine (
    .clk, .rst, .timeout(timeout_ticks), .q_valid, .q_req, .q_pop,
    .res_valid(eng_valid), .res(eng_res), .res_take(eng_take)
  );

  // Output register decouples the engine from a stalled consumer.
  assign eng_take = eng_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take) begin
      status        <= eng_res.status;
      found         <= eng_res.found;
      mac_out       <= eng_res.mac;
      expired_count <= eng_res.count;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for neighbour_cache_with_aging_core.
`timescale 1ns / 1ps
module tb_top;
  import nca_pkg::*;

  // Table requests walk the full table, so the run limit allows for ~1500
  // requests that each take a full scan, the clearing pass after reset and
  // the long result hold, several times over.
  localparam int unsigned SCAN_CYCLES   = TABLE_ENTRIES + 16;
  localparam int unsigned RANDOM_ITEMS  = 1420;
  localparam int unsigned HOLD_CYCLES   = 20000;
  localparam longint unsigned CYCLE_LIMIT = 64'd4 * (RANDOM_ITEMS + 100) * (SCAN_CYCLES + 22)
                                            + 64'd200000;
  localparam int unsigned KEY_POOL      = 24;
  localparam logic [2:0]  KIND_RSV_LAST = 3'd7;
  localparam logic [2:0]  REG_TIMEOUT   = 3'd0;   // byte address of timeout_ticks

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid, req_stall;
  logic [2:0]  kind;
  logic [63:0] key_high, key_low;
  logic [47:0] mac_in;
  logic [31:0] now;
  logic        rsp_valid, rsp_stall;
  logic [1:0]  status;
  logic        found;
  logic [47:0] mac_out;
  logic [12:0] expired_count;

  neighbour_cache_with_aging_core u_top (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid, .req_stall, .kind, .key_high, .key_low, .mac_in, .now,
    .rsp_valid, .rsp_stall, .status, .found, .mac_out, .expired_count
  );

  // Shadow copy of the table, updated in request acceptance order.
  bit          shadow_valid [TABLE_ENTRIES];
  logic [63:0] shadow_kh    [TABLE_ENTRIES];
  logic [63:0] shadow_kl    [TABLE_ENTRIES];
  logic [47:0] shadow_mac   [TABLE_ENTRIES];
  logic [31:0] shadow_used  [TABLE_ENTRIES];
  logic [31:0] shadow_timeout;

  res_t        pending_rsp[$];   // expected responses, oldest first
  int unsigned error_count;
  longint unsigned cycle_count;
  bit          hold_rsp;         // asks the response side for one long hold

  // Directed rows: typed == 1 means the response is written out by hand.
  typedef struct {
    logic [2:0]  kind;
    logic [63:0] kh;
    logic [63:0] kl;
    logic [47:0] mac;
    logic [31:0] now;
    bit          typed;
    res_t        rsp;
  } dir_row_t;
  dir_row_t dir_rows[$];

  logic [63:0] pool_kh  [KEY_POOL];
  logic [63:0] pool_kl  [KEY_POOL];
  logic [47:0] pool_mac [KEY_POOL];

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[neighbour_cache_with_aging_core] ERROR");
      $finish;
    end
  end

  function automatic int find_entry(logic [63:0] kh, logic [63:0] kl);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (shadow_valid[i] && shadow_kh[i] == kh && shadow_kl[i] == kl) return i;
    return -1;
  endfunction

  // Applies one request to the shadow table and returns its response.
  function automatic res_t cache_apply(logic [2:0] k, logic [63:0] kh, logic [63:0] kl,
                                       logic [47:0] mac, logic [31:0] t);
    res_t r;
    int   s;
    int   cnt;
    r = '0;
    r.status = ST_OK;
    cnt = 0;
    case (k)
      OP_EXISTS: begin
        s = find_entry(kh, kl);
        r.found  = (s >= 0);
        r.status = (s >= 0) ? ST_OK : ST_NOT_FOUND;
      end
      OP_LOOKUP: begin
        s = find_entry(kh, kl);
        if (s >= 0) begin
          r.found = 1'b1;
          r.mac = shadow_mac[s];
          shadow_used[s] = t;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_CREATE: begin
        if (find_entry(kh, kl) >= 0) begin
          r.status = ST_PRESENT;
        end else begin
          s = -1;
          for (int i = 0; i < TABLE_ENTRIES && s < 0; i++)
            if (!shadow_valid[i]) s = i;
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            shadow_valid[s] = 1'b1;
            shadow_kh[s]    = kh;
            shadow_kl[s]    = kl;
            shadow_mac[s]   = mac;
            shadow_used[s]  = t;
          end
        end
      end
      OP_UPDATE: begin
        s = find_entry(kh, kl);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (shadow_mac[s] != mac) begin
          shadow_mac[s]  = mac;
          shadow_used[s] = t;
        end
      end
      OP_EXPIRE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (shadow_valid[i] && (t - shadow_used[i]) >= shadow_timeout) begin
            shadow_valid[i] = 1'b0;
            if (cnt < 8191) cnt++;
          end
        r.count = cnt[CNT_W-1:0];
      end
      default: r = '0;   // reserved kinds: no effect, all-zero response
    endcase
    return r;
  endfunction

  // Response checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response status=%0d", status);
        error_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          error_count++;
        end
        if (found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, found);
          error_count++;
        end
        if (mac_out !== e.mac) begin
          $error("mac_out: expected %h, got %h", e.mac, mac_out);
          error_count++;
        end
        if (expired_count !== e.count) begin
          $error("expired_count: expected %0d, got %0d", e.count, expired_count);
          error_count++;
        end
      end
    end
  end

  // Response side: random stall per response, bursts with no stall, one long hold.
  initial begin
    int unsigned n;
    int unsigned taken;
    taken = 0;
    rsp_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end
      n = ((taken / 64) % 3 == 1) ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  task automatic apb_write(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TIMEOUT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shadow_timeout = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $error("timeout_ticks readback: expected %h, got %h", value, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drains all responses, then lets the engine settle before a register write.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_req(logic [2:0] k, logic [63:0] kh, logic [63:0] kl, logic [47:0] mac,
                          logic [31:0] t, int unsigned gap, bit typed, res_t typed_rsp);
    res_t r;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    key_high  <= kh;
    key_low   <= kl;
    mac_in    <= mac;
    now       <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    r = cache_apply(k, kh, kl, mac, t);
    pending_rsp.push_back(typed ? typed_rsp : r);
  endtask

  task automatic add_row(logic [2:0] k, logic [63:0] kh, logic [63:0] kl, logic [47:0] mac,
                         logic [31:0] t, bit typed, logic [1:0] st, logic fnd,
                         logic [47:0] m, logic [12:0] c);
    dir_row_t row;
    row.kind = k; row.kh = kh; row.kl = kl; row.mac = mac; row.now = t;
    row.typed = typed;
    row.rsp.status = status_t'(st);
    row.rsp.found = fnd;
    row.rsp.mac = m;
    row.rsp.count = c;
    dir_rows.push_back(row);
  endtask

  // Stimulus
  initial begin
    logic [63:0] ones;
    logic [31:0] tick;
    logic [2:0]  k;
    logic [63:0] kh, kl;
    logic [47:0] mac;
    int unsigned p, gap, w;
    res_t        none;
    logic [31:0] phase_timeout [4];

    ones = '1;
    none = '0;
    error_count = 0;
    cycle_count = 0;
    hold_rsp = 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    req_valid <= 1'b0; kind <= '0; key_high <= '0; key_low <= '0; mac_in <= '0; now <= '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_kh[i] = '0; shadow_kl[i] = '0; shadow_mac[i] = '0; shadow_used[i] = '0;
    end
    shadow_timeout = TIMEOUT_RESET;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: misses on an empty table, extreme keys/MACs/ticks, duplicates,
    // unchanged-MAC update, reserved kinds, expiry below, at and above the timeout.
    add_row(OP_EXISTS, '0, '0, '0, '0, 1, ST_NOT_FOUND, 0, '0, '0);
    add_row(OP_LOOKUP, ones, ones, '0, '0, 1, ST_NOT_FOUND, 0, '0, '0);
    add_row(OP_UPDATE, ones, ones, '1, '0, 1, ST_NOT_FOUND, 0, '0, '0);
    add_row(OP_CREATE, ones, ones, '1, '1, 1, ST_OK, 0, '0, '0);
    add_row(OP_CREATE, '0, '0, '0, '0, 1, ST_OK, 0, '0, '0);
    add_row(OP_CREATE, ones, ones, 48'h123, 32'd9, 1, ST_PRESENT, 0, '0, '0);
    add_row(OP_EXISTS, ones, ones, '0, '0, 1, ST_OK, 1, '0, '0);
    add_row(OP_LOOKUP, ones, ones, '0, '1, 1, ST_OK, 1, '1, '0);
    add_row(OP_UPDATE, ones, ones, '1, 32'd5, 0, ST_OK, 0, '0, '0);
    add_row(OP_UPDATE, '0, '0, 48'h5555_5555_5555, 32'd100, 0, ST_OK, 0, '0, '0);
    add_row(OP_LOOKUP, '0, '0, '0, 32'd200, 1, ST_OK, 1, 48'h5555_5555_5555, '0);
    add_row(OP_IGNORE, ones, ones, '1, '1, 1, ST_OK, 0, '0, '0);
    add_row(OP_IGNORE + 3'd1, '0, '0, '0, '0, 1, ST_OK, 0, '0, '0);
    add_row(KIND_RSV_LAST, ones, '0, '1, '1, 1, ST_OK, 0, '0, '0);
    add_row(OP_EXPIRE, '0, '0, '0, 32'd1000, 1, ST_OK, 0, '0, 13'd0);
    add_row(OP_EXPIRE, '0, '0, '0, 32'd2000, 1, ST_OK, 0, '0, 13'd2);
    add_row(OP_EXISTS, ones, ones, '0, '0, 1, ST_NOT_FOUND, 0, '0, '0);
    add_row(OP_CREATE, {32'hAAAA_AAAA, 32'h5555_5555}, {32'h5555_5555, 32'hAAAA_AAAA},
            48'hAAAA_5555_AAAA, 32'd7, 1, ST_OK, 0, '0, '0);
    add_row(OP_UPDATE, {32'hAAAA_AAAA, 32'h5555_5555}, {32'h5555_5555, 32'hAAAA_AAAA},
            48'h5555_AAAA_5555, 32'd8, 0, ST_OK, 0, '0, '0);
    foreach (dir_rows[i])
      send_req(dir_rows[i].kind, dir_rows[i].kh, dir_rows[i].kl, dir_rows[i].mac,
               dir_rows[i].now, $urandom_range(0, 3), dir_rows[i].typed, dir_rows[i].rsp);

    // Zero timeout: an expire scan at the same tick clears everything.
    wait_idle();
    apb_write(32'd0);
    send_req(OP_CREATE, 64'h1, 64'h2, 48'h3, 32'd50, 0, 0, none);
    send_req(OP_EXPIRE, '0, '0, '0, 32'd50, 0, 0, none);

    for (int i = 0; i < KEY_POOL; i++) begin
      pool_kh[i]  = {$urandom, $urandom};
      pool_kl[i]  = {$urandom, $urandom};
      pool_mac[i] = {$urandom, $urandom};
    end

    // Random phases: reset value, the two extremes, then a mid value.
    phase_timeout[0] = TIMEOUT_RESET;
    phase_timeout[1] = 32'd1;
    phase_timeout[2] = 32'hFFFF_FFFF;
    phase_timeout[3] = $urandom_range(200, 3000);
    tick = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % (RANDOM_ITEMS / 4) == 0) begin
        wait_idle();
        apb_write(phase_timeout[n / (RANDOM_ITEMS / 4)]);
      end
      if (n == 300) hold_rsp = 1'b1;                 // receiver holds off; queue backs up
      if (n == 700) begin
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      w = $urandom_range(0, 99);
      if (w < 20)      k = OP_EXISTS;
      else if (w < 45) k = OP_LOOKUP;
      else if (w < 68) k = OP_CREATE;
      else if (w < 88) k = OP_UPDATE;
      else if (w < 97) k = OP_EXPIRE;
      else             k = 3'($urandom_range(OP_IGNORE, KIND_RSV_LAST));
      p = $urandom_range(0, KEY_POOL - 1);
      if ($urandom_range(0, 9) == 0) begin
        kh = {$urandom, $urandom};
        kl = {$urandom, $urandom};
      end else begin
        kh = pool_kh[p];
        kl = pool_kl[p];
      end
      mac = $urandom_range(0, 1) ? pool_mac[p] : {$urandom, $urandom};
      if ($urandom_range(0, 29) == 0) tick = $urandom;
      else tick = tick + $urandom_range(0, 400);
      gap = ((n / 80) % 3 == 2) ? 0 : $urandom_range(0, 10);
      send_req(k, kh, kl, mac, tick, gap, 0, none);
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[neighbour_cache_with_aging_core] OK");
    end else begin
      $display("[neighbour_cache_with_aging_core] ERROR");
    end
    $finish;
  end

endmodule
